// ===== src/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ITRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When ante holds, cons must hold at the next clock edge.
`define ITRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/itrd_pkg.sv =====
// Shared types, constants and the microcode ROM of the integer-to-text unit.
package itrd_pkg;

  localparam int unsigned MaxDigits  = 16;
  localparam int unsigned NumW       = 32;
  localparam int unsigned CharW      = 8;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned RadixW     = 5;
  localparam int unsigned CfgW       = 64;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned AlphaW     = 2 * CfgW;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned StackIdxW  = $clog2(StackDepth);
  localparam int unsigned CntW       = StackIdxW + 1;
  localparam int unsigned StepW      = 4;
  localparam int unsigned DivBits    = 8;

  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDigitsLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDigitsHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRadix      = 2'd2;

  // Microprogram step addresses
  localparam logic [StepW-1:0] StepCheck = 4'd0;
  localparam logic [StepW-1:0] StepSign  = 4'd1;
  localparam logic [StepW-1:0] StepDiv0  = 4'd2;
  localparam logic [StepW-1:0] StepDiv1  = 4'd3;
  localparam logic [StepW-1:0] StepDiv2  = 4'd4;
  localparam logic [StepW-1:0] StepDiv3  = 4'd5;
  localparam logic [StepW-1:0] StepPush  = 4'd6;
  localparam logic [StepW-1:0] StepEmit  = 4'd7;
  localparam logic [StepW-1:0] StepDone  = 4'd8;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_SIGN,
    OP_DIV0,
    OP_DIV,
    OP_PUSH,
    OP_EMIT,
    OP_DONE
  } op_e;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_NONE,
    COND_NOT_OK,
    COND_MAG_NZ,
    COND_MORE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic load;
    op_e  op;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic mag_nz;
    logic more;
  } status_t;

  // Microprogram: check alphabet, optional sign, divide loop, emit loop.
  function automatic uword_t ucode_rom(logic [StepW-1:0] step);
    uword_t w;
    w = '{op: OP_DONE, cond: COND_NONE, target: StepDone};
    unique case (step)
      StepCheck: w = '{op: OP_NOP,  cond: COND_NOT_OK, target: StepDone};
      StepSign:  w = '{op: OP_SIGN, cond: COND_NONE,   target: StepDone};
      StepDiv0:  w = '{op: OP_DIV0, cond: COND_NONE,   target: StepDone};
      StepDiv1:  w = '{op: OP_DIV,  cond: COND_NONE,   target: StepDone};
      StepDiv2:  w = '{op: OP_DIV,  cond: COND_NONE,   target: StepDone};
      StepDiv3:  w = '{op: OP_DIV,  cond: COND_NONE,   target: StepDone};
      StepPush:  w = '{op: OP_PUSH, cond: COND_MAG_NZ, target: StepDiv0};
      StepEmit:  w = '{op: OP_EMIT, cond: COND_MORE,   target: StepEmit};
      StepDone:  w = '{op: OP_DONE, cond: COND_NONE,   target: StepDone};
      default:   w = '{op: OP_DONE, cond: COND_NONE,   target: StepDone};
    endcase
    return w;
  endfunction

endpackage

// ===== src/itrd_cfg.sv =====
// Configuration registers and alphabet validity check.
module itrd_cfg #(
  parameter int unsigned MaxDigits = itrd_pkg::MaxDigits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [itrd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [itrd_pkg::CfgW-1:0]     cfg_data_i,
  output logic [itrd_pkg::AlphaW-1:0]   alpha_o,
  output logic [itrd_pkg::RadixW-1:0]   radix_o,
  output logic                          ok_o
);

  logic [itrd_pkg::CfgW-1:0]   digits_low_q, digits_high_q;
  logic [itrd_pkg::RadixW-1:0] radix_q;
  logic [itrd_pkg::AlphaW-1:0] alpha;
  logic                        ok_d, ok_q;

  // Register writes; out-of-range index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_low_q  <= '0;
      digits_high_q <= '0;
      radix_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        itrd_pkg::RegDigitsLow:  digits_low_q  <= cfg_data_i;
        itrd_pkg::RegDigitsHigh: digits_high_q <= cfg_data_i;
        itrd_pkg::RegRadix:      radix_q       <= cfg_data_i[itrd_pkg::RadixW-1:0];
        default: ;
      endcase
    end
  end

  assign alpha = {digits_high_q, digits_low_q};

  // Validity: radix in range, no reserved chars, all used chars distinct
  always_comb begin
    logic [itrd_pkg::CharW-1:0] c;
    ok_d = (radix_q >= itrd_pkg::RadixW'(2)) &&
           (radix_q <= itrd_pkg::RadixW'(MaxDigits));
    for (int i = 0; i < MaxDigits; i++) begin
      c = alpha[itrd_pkg::CharW*i +: itrd_pkg::CharW];
      if (itrd_pkg::RadixW'(i) < radix_q) begin
        if (c == '0 || c == itrd_pkg::CharPlus || c == itrd_pkg::CharMinus) begin
          ok_d = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (alpha[itrd_pkg::CharW*j +: itrd_pkg::CharW] == c) begin
            ok_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
    end
  end

  assign alpha_o = alpha;
  assign radix_o = radix_q;
  assign ok_o    = ok_q;

endmodule

// ===== src/itrd_seq.sv =====
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
module itrd_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              ok_i,
  input  itrd_pkg::status_t status_i,
  output itrd_pkg::ctrl_t   ctrl_o,
  output logic              busy
);

  logic                       busy_d, busy_q;
  logic [itrd_pkg::StepW-1:0] upc_d, upc_q;
  itrd_pkg::uword_t           word;
  logic                       take;

  assign word = itrd_pkg::ucode_rom(upc_q);

  // Jump condition select
  always_comb begin
    unique case (word.cond)
      itrd_pkg::COND_NONE:   take = 1'b0;
      itrd_pkg::COND_NOT_OK: take = !ok_i;
      itrd_pkg::COND_MAG_NZ: take = status_i.mag_nz;
      itrd_pkg::COND_MORE:   take = status_i.more;
      default:               take = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (!busy_q) begin
      if (start) begin
        busy_d = 1'b1;
        upc_d  = itrd_pkg::StepCheck;
      end
    end else if (word.op == itrd_pkg::OP_DONE) begin
      busy_d = 1'b0;
    end else if (take) begin
      upc_d = word.target;
    end else begin
      upc_d = upc_q + itrd_pkg::StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= itrd_pkg::StepCheck;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

  // Control word out; idle issues no operation
  always_comb begin
    ctrl_o.load = start && !busy_q;
    ctrl_o.op   = busy_q ? word.op : itrd_pkg::OP_NOP;
  end

  assign busy = busy_q;

endmodule

// ===== src/itrd_dpath.sv =====
// Datapath: magnitude, radix divider slice, digit stack and output word register.
module itrd_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itrd_pkg::ctrl_t               ctrl_i,
  input  logic signed [itrd_pkg::NumW-1:0] number_i,
  input  logic [itrd_pkg::AlphaW-1:0]   alpha_i,
  input  logic [itrd_pkg::RadixW-1:0]   radix_i,
  output itrd_pkg::status_t             status_o,
  output logic                          valid_o,
  output logic [itrd_pkg::CharW-1:0]    character_o,
  output logic                          final_res_o
);

  logic [itrd_pkg::NumW-1:0]    mag_d, mag_q;
  logic [itrd_pkg::DigitW-1:0]  rem_d, rem_q;
  logic                         sign_q;
  logic [itrd_pkg::CntW-1:0]    cnt_q, cnt_m1;
  logic [itrd_pkg::DigitW-1:0]  stack_q [itrd_pkg::StackDepth];
  logic [itrd_pkg::DigitW-1:0]  top_digit;
  logic [itrd_pkg::DivBits-1:0] qbits;
  logic                         valid_q, final_q;
  logic [itrd_pkg::CharW-1:0]   char_q;

  // Restoring division, DivBits quotient bits per cycle
  always_comb begin
    logic [itrd_pkg::DigitW-1:0] r;
    logic [itrd_pkg::RadixW-1:0] t;
    r = (ctrl_i.op == itrd_pkg::OP_DIV0) ? '0 : rem_q;
    for (int k = 0; k < itrd_pkg::DivBits; k++) begin
      t = {r, mag_q[itrd_pkg::NumW-1-k]};
      qbits[itrd_pkg::DivBits-1-k] = (t >= radix_i);
      if (t >= radix_i) begin
        t = t - radix_i;
      end
      r = t[itrd_pkg::DigitW-1:0];
    end
    rem_d = r;
    mag_d = {mag_q[itrd_pkg::NumW-itrd_pkg::DivBits-1:0], qbits};
  end

  assign cnt_m1    = cnt_q - itrd_pkg::CntW'(1);
  assign top_digit = stack_q[cnt_m1[itrd_pkg::StackIdxW-1:0]];

  // Working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      cnt_q <= '0;
    end else if (ctrl_i.op == itrd_pkg::OP_PUSH) begin
      cnt_q <= cnt_q + itrd_pkg::CntW'(1);
    end else if (ctrl_i.op == itrd_pkg::OP_EMIT) begin
      cnt_q <= cnt_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sign_q <= number_i[itrd_pkg::NumW-1];
      // negation of the most negative value gives 2^31 as unsigned
      mag_q  <= number_i[itrd_pkg::NumW-1] ? (~number_i + itrd_pkg::NumW'(1))
                                            : number_i;
    end else if (ctrl_i.op == itrd_pkg::OP_DIV0 || ctrl_i.op == itrd_pkg::OP_DIV) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
    if (ctrl_i.op == itrd_pkg::OP_PUSH) begin
      stack_q[cnt_q[itrd_pkg::StackIdxW-1:0]] <= rem_q;
    end
  end

  // Output word register, one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (ctrl_i.op == itrd_pkg::OP_EMIT) ||
                 (ctrl_i.op == itrd_pkg::OP_SIGN && sign_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == itrd_pkg::OP_SIGN) begin
      char_q  <= itrd_pkg::CharMinus;
      final_q <= 1'b0;
    end else if (ctrl_i.op == itrd_pkg::OP_EMIT) begin
      char_q  <= alpha_i[{top_digit, 3'b000} +: itrd_pkg::CharW];
      final_q <= (cnt_q == itrd_pkg::CntW'(1));
    end
  end

  assign status_o.mag_nz = (mag_q != '0);
  assign status_o.more   = (cnt_q != itrd_pkg::CntW'(1));

  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign final_res_o = final_q;

endmodule

// ===== src/int_to_radix_digits_unit.sv =====
// Top level of the signed integer to radix text converter.
//
// Usage: load the alphabet with the write port (index 0: characters for digit
// values 0..7, index 1: values 8..15, index 2: radix), only while busy is low.
// Pulse start with number_i while busy is low; the number is taken at that
// edge and busy rises. Characters leave most significant digit first, each
// for one cycle with valid_o high; a negative number leads with a minus word.
// final_res_o marks the last word. An invalid alphabet gives no words.
// Per digit the divider slice resolves 8 quotient bits a cycle over the
// divide steps Div0 to Div3, then takes a push step; each word is one
// emit step.
// The next item may start in the cycle after busy falls.
// Reset clears the control and configuration registers, leaving the alphabet
// invalid, and idles the sequencer. The receiver cannot stall: every word is
// valid for exactly one cycle and must be taken then.
`include "assert_macros.svh"

module int_to_radix_digits_unit #(
  parameter int unsigned MaxDigits = itrd_pkg::MaxDigits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [itrd_pkg::NumW-1:0] number_i,
  input  logic                             cfg_we_i,
  input  logic [itrd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [itrd_pkg::CfgW-1:0]        cfg_data_i,
  output logic                             valid_o,
  output logic [itrd_pkg::CharW-1:0]       character_o,
  output logic                             final_res_o
);

  logic [itrd_pkg::AlphaW-1:0] alpha;
  logic [itrd_pkg::RadixW-1:0] radix;
  logic                        ok;
  itrd_pkg::ctrl_t             ctrl;
  itrd_pkg::status_t           status;

  itrd_cfg #(
    .MaxDigits (MaxDigits)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .alpha_o    (alpha),
    .radix_o    (radix),
    .ok_o       (ok)
  );

  itrd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .ok_i     (ok),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  itrd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .number_i    (number_i),
    .alpha_i     (alpha),
    .radix_i     (radix),
    .status_o    (status),
    .valid_o     (valid_o),
    .character_o (character_o),
    .final_res_o (final_res_o)
  );

  // Words only go out while an item is in progress
  `ITRD_ASSERT(a_valid_in_busy, !valid_o || busy, "word strobe outside busy")
  // The last word of an item is never directly followed by another word
  `ITRD_ASSERT_NEXT(a_final_gap, valid_o && final_res_o, !valid_o, "word after final")
  // An accepted item starts the sequencer with no stale word pending
  `ITRD_ASSERT_NEXT(a_start_busy, start && !busy, busy && !valid_o, "start not taken")

endmodule
